FILE: sv/deadline_timer_queue_macros.svh
// Assertion macros for the deadline timer queue.
`ifndef DEADLINE_TIMER_QUEUE_MACROS_SVH
`define DEADLINE_TIMER_QUEUE_MACROS_SVH
// Assert that an antecedent implies a consequent in the following clock cycle.
`define DTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
// Assert that an expression holds at every clock edge out of reset.
`define DTQ_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`endif

FILE: sv/dtq_pkg.sv
// Package: types and constants of the deadline timer queue.
package dtq_pkg;
    localparam int Capacity = 64;
    localparam int MaxResults = 64;
    localparam int IdxW = $clog2(Capacity);
    localparam int CntW = $clog2(Capacity + 1);
    localparam int DlW = 49;
    localparam int IdW = 32;

    typedef enum logic [1:0] {
        REQ_ADD = 2'd0, REQ_REMOVE = 2'd1, REQ_QUERY = 2'd2, REQ_RUN = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_FULL = 2'd1, ST_NOT_FOUND = 2'd2, ST_NONE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_RETIRE, S_SWEEP, S_RESULT
    } t_state;

    // Control from sequencer to the entry table.
    typedef struct packed {
        logic            wr_en;
        logic [IdxW-1:0] wr_idx;
        logic [DlW-1:0]  wr_dl;
        logic [IdW-1:0]  wr_id;
        logic            wr_cb;
        logic            clr_en;
        logic [IdxW-1:0] clr_idx;
        logic            rd_en;
        logic [IdxW-1:0] rd_idx;
    } t_tbl_ctl;
endpackage

FILE: sv/deadline_timer_queue.sv
// Top level: deadline timer queue sequencer with one shared compare unit.
//  channel | direction | handshake          | payload
//  request | in        | i_valid / o_ready  | i_req_type .. i_has_callback
//  result  | out       | o_valid / i_ready  | o_status .. o_last
// Add and query: one scan of the table, then a result state; a new request word is
//   accepted only once the last one has left its result state. A remove that finds
//   its deadline adds a sweep. Run: one scan and one retire per reported timer, then a
//   last scan (nothing found or MaxResults reported) and a sweep; one table read per compare.
// Reset clears all valid flags at once; no clearing pass. A stalled result word holds
//   the sequencer at its next result load.
`include "deadline_timer_queue_macros.svh"
module deadline_timer_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [47:0] i_now,
    input  logic [31:0] i_delay_ms,
    input  logic [48:0] i_deadline,
    input  logic [31:0] i_timer_id,
    input  logic        i_has_callback,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_timer_id_res,
    output logic [48:0] o_deadline_res,
    output logic signed [31:0] o_wait_ms,
    output logic        o_last
);
    localparam int DlW = dtq_pkg::DlW;
    localparam int IdW = dtq_pkg::IdW;
    localparam int IdxW = dtq_pkg::IdxW;
    localparam int CntW = dtq_pkg::CntW;

    dtq_pkg::t_state r_state, n_state;
    dtq_pkg::t_tbl_ctl w_ctl;
    logic w_tv, w_tcb, w_full;
    logic [DlW-1:0] w_tdl;
    logic [IdW-1:0] w_tid;
    logic [IdxW-1:0] w_free;

    dtq_table u_table (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .o_valid(w_tv), .o_dl(w_tdl), .o_id(w_tid), .o_cb(w_tcb),
        .o_full(w_full), .o_free_idx(w_free)
    );

    // request registers
    logic [1:0] r_req;
    logic [47:0] r_now;
    logic [DlW-1:0] r_key_dl;
    logic [IdW-1:0] r_key_id;
    logic r_cb;
    logic [IdW-1:0] r_id_ctr;
    // scan state
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [IdxW-1:0] r_pidx;
    logic r_pend;
    logic r_any, n_any;
    logic r_hit, n_hit;
    logic [IdxW-1:0] r_hidx, n_hidx;
    logic [DlW-1:0] r_bdl, n_bdl;
    logic [IdW-1:0] r_bid, n_bid;
    logic [CntW-1:0] r_ccnt, n_ccnt;
    logic [CntW-1:0] r_nres, n_nres;
    // output register
    logic r_ovalid, n_ovalid;
    logic [1:0] r_ost;
    logic [IdW-1:0] r_oid;
    logic [DlW-1:0] r_odl;
    logic [31:0] r_owait;
    logic r_olast;

    logic w_take, w_pop, w_scan_done, w_retire, w_finish, w_last_rep;
    logic w_is_dl, w_is_exp, w_cand, w_better;
    logic [DlW-1:0] w_add_dl;
    logic [IdW-1:0] w_nid;
    logic [DlW-1:0] w_diff;
    dtq_pkg::t_status w_fin_st;
    logic [IdW-1:0] w_fin_id;
    logic [DlW-1:0] w_fin_dl;
    logic [31:0] w_fin_wait;

    assign w_take = i_valid && o_ready;
    assign w_pop = r_ovalid && i_ready;
    assign w_scan_done = r_pend && (r_pidx == IdxW'(dtq_pkg::Capacity - 1));
    assign w_retire = (r_state == dtq_pkg::S_RETIRE) && (!r_ovalid || w_pop);
    assign w_finish = (r_state == dtq_pkg::S_RESULT) && (!r_ovalid || w_pop);
    assign w_add_dl = DlW'(i_now) + DlW'(i_delay_ms);
    assign w_nid = r_id_ctr + IdW'(1);
    // the report is last when it was the only candidate left or the report limit is hit
    assign w_last_rep = (r_ccnt == CntW'(1)) ||
                        (r_nres == CntW'(dtq_pkg::MaxResults - 1));

    // shared compare unit on the entry just read
    assign w_is_dl = w_tv && (w_tdl == r_key_dl);
    assign w_is_exp = w_tv && (w_tdl <= DlW'(r_now));
    assign w_cand = (r_req == dtq_pkg::REQ_RUN) ? (w_is_exp && w_tcb) : w_tv;
    assign w_better = !r_any || (w_tdl < r_bdl) ||
                      ((r_req == dtq_pkg::REQ_RUN) && (w_tdl == r_bdl) && (w_tid < r_bid));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dtq_pkg::S_IDLE:   if (w_take) n_state = dtq_pkg::S_SCAN;
            dtq_pkg::S_SCAN:   if (w_scan_done) begin
                if (r_req == dtq_pkg::REQ_RUN)
                    n_state = (n_any && (r_nres != CntW'(dtq_pkg::MaxResults)))
                              ? dtq_pkg::S_RETIRE : dtq_pkg::S_SWEEP;
                else if (r_req == dtq_pkg::REQ_REMOVE && n_any)
                    n_state = dtq_pkg::S_SWEEP;
                else
                    n_state = dtq_pkg::S_RESULT;
            end
            dtq_pkg::S_RETIRE: if (w_retire) n_state = dtq_pkg::S_SCAN;
            dtq_pkg::S_SWEEP:  if (w_scan_done) n_state = dtq_pkg::S_RESULT;
            dtq_pkg::S_RESULT: if (w_finish) n_state = dtq_pkg::S_IDLE;
            default:           n_state = dtq_pkg::S_IDLE;
        endcase
    end

    // scan accumulation; cleared on a new request and after each retired report
    always_comb begin
        n_any = r_any;
        n_hit = r_hit;
        n_hidx = r_hidx;
        n_bdl = r_bdl;
        n_bid = r_bid;
        n_ccnt = r_ccnt;
        if (w_take || w_retire) begin
            n_any = 1'b0;
            n_hit = 1'b0;
            n_ccnt = '0;
        end else if (r_pend && r_state == dtq_pkg::S_SCAN) begin
            unique case (r_req)
                dtq_pkg::REQ_ADD: if (!r_hit && w_tv && w_tdl == r_key_dl && w_tid == w_nid) begin
                    n_hit = 1'b1;
                    n_hidx = r_pidx;
                end
                dtq_pkg::REQ_REMOVE: if (w_is_dl) n_any = 1'b1;
                default: begin
                    if (w_cand) n_ccnt = r_ccnt + CntW'(1);
                    if (w_cand && w_better) begin
                        n_any = 1'b1;
                        n_bdl = w_tdl;
                        n_bid = w_tid;
                        n_hidx = r_pidx;
                    end
                end
            endcase
        end
    end

    // table control
    always_comb begin
        w_ctl = '0;
        w_ctl.rd_en = (r_state == dtq_pkg::S_SCAN || r_state == dtq_pkg::S_SWEEP);
        w_ctl.rd_idx = r_cnt[IdxW-1:0];
        w_ctl.wr_dl = r_key_dl;
        w_ctl.wr_id = w_nid;
        w_ctl.wr_cb = r_cb;
        w_ctl.wr_idx = r_hit ? r_hidx : w_free;
        if (w_finish && r_req == dtq_pkg::REQ_ADD && (r_hit || !w_full))
            w_ctl.wr_en = 1'b1;
        if (w_retire) begin
            w_ctl.clr_en = 1'b1;
            w_ctl.clr_idx = r_hidx;
        end
        if (r_state == dtq_pkg::S_SWEEP && r_pend) begin
            w_ctl.clr_idx = r_pidx;
            if (r_req == dtq_pkg::REQ_REMOVE)
                w_ctl.clr_en = w_is_dl && (w_tid == r_key_id);
            else
                w_ctl.clr_en = w_is_exp && !w_tcb;
        end
    end

    // next scan counter, report count and output valid
    always_comb begin
        n_cnt = r_cnt;
        if (w_scan_done || r_state == dtq_pkg::S_RETIRE)
            n_cnt = '0;
        else if ((r_state == dtq_pkg::S_SCAN || r_state == dtq_pkg::S_SWEEP) &&
                 (r_cnt != CntW'(dtq_pkg::Capacity)))
            n_cnt = r_cnt + CntW'(1);
        n_nres = r_nres;
        if (w_take)
            n_nres = '0;
        else if (w_retire)
            n_nres = r_nres + CntW'(1);
        n_ovalid = r_ovalid && !w_pop;
        if (w_retire)
            n_ovalid = 1'b1;
        else if (w_finish)
            n_ovalid = (r_req != dtq_pkg::REQ_RUN) || (r_nres == '0);
    end

    // closing result word of a request
    always_comb begin
        w_fin_st = dtq_pkg::ST_NONE;
        w_fin_id = '0;
        w_fin_dl = '0;
        w_fin_wait = '0;
        unique case (r_req)
            dtq_pkg::REQ_ADD: begin
                if (r_hit || !w_full) begin
                    w_fin_st = dtq_pkg::ST_OK;
                    w_fin_id = w_nid;
                    w_fin_dl = r_key_dl;
                end else begin
                    w_fin_st = dtq_pkg::ST_FULL;
                end
            end
            dtq_pkg::REQ_REMOVE: w_fin_st = r_any ? dtq_pkg::ST_OK : dtq_pkg::ST_NOT_FOUND;
            dtq_pkg::REQ_QUERY: begin
                if (r_any) begin
                    w_fin_st = dtq_pkg::ST_OK;
                    w_fin_dl = r_bdl;
                    if (r_bdl <= DlW'(r_now)) w_fin_wait = '0;
                    else if (w_diff > DlW'(32'h7FFF_FFFF)) w_fin_wait = 32'h7FFF_FFFF;
                    else w_fin_wait = w_diff[31:0];
                end else begin
                    w_fin_wait = '1;
                end
            end
            default: w_fin_st = dtq_pkg::ST_NONE;
        endcase
    end

    assign w_diff = r_bdl - DlW'(r_now);
    assign o_ready = (r_state == dtq_pkg::S_IDLE);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtq_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_id_ctr <= '0;
            r_pend <= 1'b0;
            r_cnt <= '0;
            r_nres <= '0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
            r_pend <= w_ctl.rd_en && (r_cnt != CntW'(dtq_pkg::Capacity));
            r_cnt <= n_cnt;
            r_nres <= n_nres;
            if (w_ctl.wr_en) r_id_ctr <= w_nid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pidx <= r_cnt[IdxW-1:0];
        r_any <= n_any;
        r_hit <= n_hit;
        r_hidx <= n_hidx;
        r_bdl <= n_bdl;
        r_bid <= n_bid;
        r_ccnt <= n_ccnt;
        if (w_take) begin
            r_req <= i_req_type;
            r_now <= i_now;
            r_key_dl <= (i_req_type == dtq_pkg::REQ_ADD) ? w_add_dl : i_deadline;
            r_key_id <= i_timer_id;
            r_cb <= i_has_callback;
        end
        if (w_retire) begin
            r_ost <= dtq_pkg::ST_OK;
            r_oid <= r_bid;
            r_odl <= r_bdl;
            r_owait <= '0;
            r_olast <= w_last_rep;
        end else if (w_finish) begin
            r_ost <= w_fin_st;
            r_oid <= w_fin_id;
            r_odl <= w_fin_dl;
            r_owait <= w_fin_wait;
            r_olast <= 1'b1;
        end
    end

    assign o_valid = r_ovalid;
    assign o_status = r_ost;
    assign o_timer_id_res = r_oid;
    assign o_deadline_res = r_odl;
    assign o_wait_ms = r_owait;
    assign o_last = r_olast;

    `DTQ_ASSERT_ALWAYS(a_ready_idle, i_clk, i_rst_n, !(o_ready && r_state != dtq_pkg::S_IDLE))
    `DTQ_ASSERT_NEXT(a_take_scan, i_clk, i_rst_n, w_take, r_state == dtq_pkg::S_SCAN)
    `DTQ_ASSERT_ALWAYS(a_nres_cap, i_clk, i_rst_n, r_nres <= CntW'(dtq_pkg::MaxResults))
endmodule

FILE: sv/dtq_table.sv
// Entry table: valid flags in flops, payload in a memory with registered read.
module dtq_table (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  dtq_pkg::t_tbl_ctl       i_ctl,
    output logic                    o_valid,
    output logic [dtq_pkg::DlW-1:0] o_dl,
    output logic [dtq_pkg::IdW-1:0] o_id,
    output logic                    o_cb,
    output logic                    o_full,
    output logic [dtq_pkg::IdxW-1:0] o_free_idx
);
    logic [dtq_pkg::Capacity-1:0] r_valid;
    logic [dtq_pkg::DlW+dtq_pkg::IdW:0] r_mem [dtq_pkg::Capacity];
    logic [dtq_pkg::DlW+dtq_pkg::IdW:0] r_rd;
    logic r_rd_valid;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_ctl.clr_en) r_valid[i_ctl.clr_idx] <= 1'b0;
            if (i_ctl.wr_en) r_valid[i_ctl.wr_idx] <= 1'b1;
        end
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) r_mem[i_ctl.wr_idx] <= {i_ctl.wr_cb, i_ctl.wr_id, i_ctl.wr_dl};
        if (i_ctl.rd_en) begin
            r_rd <= r_mem[i_ctl.rd_idx];
            r_rd_valid <= r_valid[i_ctl.rd_idx];
        end
    end

    // first free slot
    always_comb begin
        o_full = 1'b1;
        o_free_idx = '0;
        for (int i = dtq_pkg::Capacity - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                o_full = 1'b0;
                o_free_idx = dtq_pkg::IdxW'(i);
            end
        end
    end

    assign o_valid = r_rd_valid;
    assign o_dl = r_rd[dtq_pkg::DlW-1:0];
    assign o_id = r_rd[dtq_pkg::DlW+dtq_pkg::IdW-1:dtq_pkg::DlW];
    assign o_cb = r_rd[dtq_pkg::DlW+dtq_pkg::IdW];
endmodule

FILE: sim/tb.sv
// Self-checking testbench for the deadline timer queue: table-driven words, overflow fill, random traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumRandom = 320;
    localparam int WatchdogLimit = 200000;

    typedef struct {
        dtq_pkg::t_status status;
        logic [31:0] id;
        logic [48:0] dl;
        logic [31:0] wait_v;
        logic        last;
    } t_res;

    typedef struct {
        dtq_pkg::t_req    req;
        logic [47:0] now;
        logic [31:0] delay;
        logic [48:0] dl;
        logic [31:0] id;
        logic        cb;
        logic        has_exp;
        dtq_pkg::t_status exp_status;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_req_type = '0;
    logic [47:0] i_now = '0;
    logic [31:0] i_delay_ms = '0;
    logic [48:0] i_deadline = '0;
    logic [31:0] i_timer_id = '0;
    logic        i_has_callback = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_timer_id_res;
    logic [48:0] o_deadline_res;
    logic signed [31:0] o_wait_ms;
    logic        o_last;

    deadline_timer_queue dut (.*);

    // Shadow copy of the timer table
    logic        tv[dtq_pkg::Capacity];
    logic [48:0] tdl[dtq_pkg::Capacity];
    logic [31:0] tid[dtq_pkg::Capacity];
    logic        tcb[dtq_pkg::Capacity];
    logic [31:0] next_id;

    t_res   pending_results[$];
    dtq_pkg::t_status row_status[$];
    int     errors = 0;
    int     n_words = 0;
    int     n_results = 0;
    int     n_timers_fired = 0;
    int     idle_cycles = 0;
    logic   hold_off = 1'b0;
    logic   stim_done = 1'b0;
    logic [47:0] clock_ms = 48'd1000;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void push_res(dtq_pkg::t_status s, logic [31:0] id, logic [48:0] dl,
                                     logic [31:0] w, logic last);
        t_res r;
        r.status = s; r.id = id; r.dl = dl; r.wait_v = w; r.last = last;
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Predict the result words of one accepted request word
    function automatic void predict_timer(dtq_pkg::t_req req, logic [47:0] now,
                                          logic [31:0] delay, logic [48:0] dl_in,
                                          logic [31:0] id_in, logic cb);
        logic [48:0] dl;
        logic [31:0] nid;
        logic [48:0] mn;
        logic [63:0] w;
        int slot, best, n;
        logic found, any;
        case (req)
            dtq_pkg::REQ_ADD: begin
                dl = 49'(now) + 49'(delay);
                nid = next_id + 32'd1;
                slot = -1;
                for (int i = 0; i < dtq_pkg::Capacity; i++)
                    if (slot < 0 && tv[i] && tdl[i] == dl && tid[i] == nid) slot = i;
                for (int i = 0; i < dtq_pkg::Capacity; i++)
                    if (slot < 0 && !tv[i]) slot = i;
                if (slot < 0) begin
                    push_res(dtq_pkg::ST_FULL, '0, '0, '0, 1'b1);
                end else begin
                    next_id = nid;
                    tv[slot] = 1'b1; tdl[slot] = dl; tid[slot] = nid; tcb[slot] = cb;
                    push_res(dtq_pkg::ST_OK, nid, dl, '0, 1'b1);
                end
            end
            dtq_pkg::REQ_REMOVE: begin
                found = 1'b0;
                for (int i = 0; i < dtq_pkg::Capacity; i++)
                    if (tv[i] && tdl[i] == dl_in) found = 1'b1;
                if (found)
                    for (int i = 0; i < dtq_pkg::Capacity; i++)
                        if (tv[i] && tdl[i] == dl_in && tid[i] == id_in) tv[i] = 1'b0;
                push_res(found ? dtq_pkg::ST_OK : dtq_pkg::ST_NOT_FOUND, '0, '0, '0, 1'b1);
            end
            dtq_pkg::REQ_QUERY: begin
                any = 1'b0; mn = '0;
                for (int i = 0; i < dtq_pkg::Capacity; i++)
                    if (tv[i] && (!any || tdl[i] < mn)) begin
                        mn = tdl[i]; any = 1'b1;
                    end
                if (!any) begin
                    push_res(dtq_pkg::ST_NONE, '0, '0, 32'hFFFF_FFFF, 1'b1);
                end else begin
                    if (mn <= 49'(now)) w = 0;
                    else begin
                        w = 64'(mn) - 64'(now);
                        if (w > 64'h7FFF_FFFF) w = 64'h7FFF_FFFF;
                    end
                    push_res(dtq_pkg::ST_OK, '0, mn, w[31:0], 1'b1);
                end
            end
            default: begin
                n = 0;
                while (n < dtq_pkg::MaxResults) begin
                    best = -1;
                    for (int i = 0; i < dtq_pkg::Capacity; i++) begin
                        if (!tv[i] || !tcb[i] || tdl[i] > 49'(now)) continue;
                        if (best < 0 || tdl[i] < tdl[best] ||
                            (tdl[i] == tdl[best] && tid[i] < tid[best])) best = i;
                    end
                    if (best < 0) break;
                    push_res(dtq_pkg::ST_OK, tid[best], tdl[best], '0, 1'b0);
                    tv[best] = 1'b0;
                    n++;
                end
                for (int i = 0; i < dtq_pkg::Capacity; i++)
                    if (tv[i] && !tcb[i] && tdl[i] <= 49'(now)) tv[i] = 1'b0;
                if (n == 0) push_res(dtq_pkg::ST_NONE, '0, '0, '0, 1'b1);
                else pending_results[$].last = 1'b1;
                n_timers_fired += n;
            end
        endcase
    endfunction

    // Present one request word and hold it until accepted
    task automatic send_word(dtq_pkg::t_req req, logic [47:0] now, logic [31:0] delay,
                             logic [48:0] dl, logic [31:0] id, logic cb);
        i_valid <= 1'b1;
        i_req_type <= req;
        i_now <= now;
        i_delay_ms <= delay;
        i_deadline <= dl;
        i_timer_id <= id;
        i_has_callback <= cb;
        do @(posedge i_clk); while (!o_ready);
        predict_timer(req, now, delay, dl, id, cb);
        n_words++;
    endtask

    task automatic idle_cycles_n(int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Pick a deadline of a live timer most of the time, so removes hit
    function automatic void pick_live(output logic [48:0] dl, output logic [31:0] id);
        int k;
        dl = 49'({$urandom, $urandom});
        id = $urandom;
        k = $urandom_range(0, dtq_pkg::Capacity - 1);
        for (int j = 0; j < dtq_pkg::Capacity; j++)
            if (tv[(k + j) % dtq_pkg::Capacity]) begin
                dl = tdl[(k + j) % dtq_pkg::Capacity];
                id = ($urandom_range(0, 3) != 0) ? tid[(k + j) % dtq_pkg::Capacity] : $urandom;
                return;
            end
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: unexpected result word status=%0d", o_status);
            end else begin
                e = pending_results.pop_front();
                if (o_status !== e.status || o_timer_id_res !== e.id ||
                    o_deadline_res !== e.dl || o_wait_ms !== e.wait_v || o_last !== e.last) begin
                    errors++;
                    if (errors <= 10)
                        $display({"ERROR: exp st=%0d id=%0d dl=%0d wait=%0d last=%0b, ",
                                  "got st=%0d id=%0d dl=%0d wait=%0d last=%0b"},
                                 e.status, e.id, e.dl, $signed(e.wait_v), e.last, o_status,
                                 o_timer_id_res, o_deadline_res, o_wait_ms, o_last);
                end
                if (row_status.size() != 0 && e.last) begin
                    if (o_status !== row_status.pop_front()) begin
                        errors++;
                        if (errors <= 10) $display("ERROR: directed row status %0d", o_status);
                    end
                end
            end
        end
    end

    // Receiver: own stall pattern plus a long hold-off window
    initial begin
        int phase;
        phase = 0;
        forever begin
            @(posedge i_clk);
            phase++;
            if (hold_off) i_ready <= 1'b0;
            else if ((phase / 200) % 3 == 0) i_ready <= 1'b1;
            else i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || hold_off ||
            (pending_results.size() == 0 && !i_valid && !stim_done)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    t_row rows[$];

    function automatic void add_row(dtq_pkg::t_req req, logic [47:0] now, logic [31:0] delay,
                                    logic [48:0] dl, logic [31:0] id, logic cb,
                                    logic has_exp, dtq_pkg::t_status st);
        t_row r;
        r.req = req; r.now = now; r.delay = delay; r.dl = dl; r.id = id; r.cb = cb;
        r.has_exp = has_exp; r.exp_status = st;
        rows.insert(rows.size(), r);
    endfunction

    initial begin
        logic [48:0] dl;
        logic [31:0] id;
        int burst, r;
        dtq_pkg::t_req req;
        for (int i = 0; i < dtq_pkg::Capacity; i++) begin
            tv[i] = 0; tdl[i] = 0; tid[i] = 0; tcb[i] = 0;
        end
        next_id = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: empty cases, extremes, every request kind
        add_row(dtq_pkg::REQ_QUERY, 48'd0, 0, 0, 0, 0, 1, dtq_pkg::ST_NONE);
        add_row(dtq_pkg::REQ_RUN, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, 1, dtq_pkg::ST_NONE);
        add_row(dtq_pkg::REQ_REMOVE, 48'd0, 0, 49'h1_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0, 1,
                dtq_pkg::ST_NOT_FOUND);
        add_row(dtq_pkg::REQ_ADD, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 1, 1, dtq_pkg::ST_OK);
        add_row(dtq_pkg::REQ_ADD, 48'd0, 32'd0, 0, 0, 1, 1, dtq_pkg::ST_OK);
        add_row(dtq_pkg::REQ_ADD, 48'd0, 32'd0, 0, 0, 0, 1, dtq_pkg::ST_OK);
        add_row(dtq_pkg::REQ_ADD, 48'd100, 32'd50, 0, 0, 1, 1, dtq_pkg::ST_OK);
        add_row(dtq_pkg::REQ_QUERY, 48'd0, 0, 0, 0, 0, 0, dtq_pkg::ST_OK);
        add_row(dtq_pkg::REQ_QUERY, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, 0, dtq_pkg::ST_OK);
        add_row(dtq_pkg::REQ_REMOVE, 48'd0, 0, 49'd150, 32'd99, 0, 1, dtq_pkg::ST_OK);
        add_row(dtq_pkg::REQ_REMOVE, 48'd0, 0, 49'd150, 32'd4, 0, 1, dtq_pkg::ST_OK);
        add_row(dtq_pkg::REQ_ADD, 48'd5, 32'hFFFF_FFFF, 0, 0, 1, 0, dtq_pkg::ST_OK);
        add_row(dtq_pkg::REQ_QUERY, 48'd0, 0, 0, 0, 0, 0, dtq_pkg::ST_OK);
        add_row(dtq_pkg::REQ_RUN, 48'd10, 0, 0, 0, 0, 0, dtq_pkg::ST_OK);
        add_row(dtq_pkg::REQ_RUN, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, 0, dtq_pkg::ST_OK);
        // the far-future timer is still pending
        add_row(dtq_pkg::REQ_QUERY, 48'd0, 0, 0, 0, 0, 1, dtq_pkg::ST_OK);
        foreach (rows[k]) begin
            if (rows[k].has_exp) row_status.insert(row_status.size(), rows[k].exp_status);
            send_word(rows[k].req, rows[k].now, rows[k].delay, rows[k].dl, rows[k].id,
                      rows[k].cb);
            wait_drained();
        end

        // Fill the table to overflow, then expire it with one run
        for (int k = 0; k < dtq_pkg::Capacity + 3; k++)
            send_word(dtq_pkg::REQ_ADD, 48'd2000, $urandom_range(0, 20), 0, 0,
                      1'($urandom_range(0, 1)));
        send_word(dtq_pkg::REQ_QUERY, 48'd2005, 0, 0, 0, 0);
        wait_drained();
        send_word(dtq_pkg::REQ_RUN, 48'd2100, 0, 0, 0, 0);

        // Long receiver hold-off while the sender keeps offering
        hold_off <= 1'b1;
        fork
            begin
                repeat (600) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            for (int k = 0; k < 6; k++)
                send_word(dtq_pkg::REQ_QUERY, 48'($urandom_range(0, 5000)), 0, 0, 0, 0);
        join
        wait_drained();

        // Random traffic in bursts; time mostly advances, deadlines cluster
        r = 0;
        while (r < NumRandom) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && r < NumRandom; b++) begin
                clock_ms = clock_ms + 48'($urandom_range(0, 30));
                if ($urandom_range(0, 40) == 0)
                    clock_ms = 48'({$urandom, $urandom});
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: req = dtq_pkg::REQ_ADD;
                    4, 5: req = dtq_pkg::REQ_REMOVE;
                    6, 7: req = dtq_pkg::REQ_QUERY;
                    default: req = dtq_pkg::REQ_RUN;
                endcase
                pick_live(dl, id);
                send_word(req, clock_ms,
                          ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 80),
                          dl, id, $urandom_range(0, 3) != 0);
                r++;
            end
            if ($urandom_range(0, 20) == 0) wait_drained();
            else idle_cycles_n($urandom_range(0, 30));
        end

        wait_drained();
        stim_done <= 1'b1;
        repeat (300) @(posedge i_clk);
        $display("Sent %0d request words, checked %0d result words, %0d timers fired.",
                 n_words, n_results, n_timers_fired);
        if (errors == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
